/* hw/rtl/bvrr_pkg.sv */
// Package for the bone vector roll to rotation unit.
// Holds widths, register indexes, the CORDIC arctangent table and shared helpers.
// No dependencies.
`default_nettype none
package bvrr_pkg;
	localparam int FracBits = 30;
	localparam int DataW = 32;
	localparam int CordicSteps = 30;
	localparam int IdxW = 2;

	typedef enum logic [IdxW-1:0] {
		REG_NEAR_NEG_Y = 2'd0,
		REG_DEGENERATE = 2'd1,
		REG_DEADBAND   = 2'd2,
		REG_SPARE      = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		CASE_GENERAL = 2'd0,
		CASE_NEAR    = 2'd1,
		CASE_EXACT   = 2'd2,
		CASE_UNUSED  = 2'd3
	} base_case_t;

	localparam logic signed [33:0] CordicGain = 34'sd652032874;

	function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
		logic signed [33:0] v;
		begin
			case (i)
				5'd0: v = 34'sd536870912;  5'd1: v = 34'sd316933406;
				5'd2: v = 34'sd167458907;  5'd3: v = 34'sd85004756;
				5'd4: v = 34'sd42667331;   5'd5: v = 34'sd21354465;
				5'd6: v = 34'sd10679838;   5'd7: v = 34'sd5340245;
				5'd8: v = 34'sd2670163;    5'd9: v = 34'sd1335087;
				5'd10: v = 34'sd667544;    5'd11: v = 34'sd333772;
				5'd12: v = 34'sd166886;    5'd13: v = 34'sd83443;
				5'd14: v = 34'sd41722;     5'd15: v = 34'sd20861;
				5'd16: v = 34'sd10430;     5'd17: v = 34'sd5215;
				5'd18: v = 34'sd2608;      5'd19: v = 34'sd1304;
				5'd20: v = 34'sd652;       5'd21: v = 34'sd326;
				5'd22: v = 34'sd163;       5'd23: v = 34'sd81;
				5'd24: v = 34'sd41;        5'd25: v = 34'sd20;
				5'd26: v = 34'sd10;        5'd27: v = 34'sd5;
				5'd28: v = 34'sd3;         5'd29: v = 34'sd1;
				default: v = 34'sd0;
			endcase
			atan_entry = v;
		end
	endfunction
endpackage
`default_nettype wire

/* hw/rtl/bvrr_cordic.sv */
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
// Depends on bvrr_pkg for the gain and arctangent table.
`default_nettype none
module bvrr_cordic
	import bvrr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_vld,
	input  wire logic signed [33:0] in_ang,
	output logic                    out_vld,
	output logic signed [33:0]      out_x,
	output logic signed [33:0]      out_y
);
	logic               vld_s [CordicSteps+1];
	logic signed [33:0] x_s   [CordicSteps+1];
	logic signed [33:0] y_s   [CordicSteps+1];
	logic signed [33:0] a_s   [CordicSteps+1];

	always_comb begin
		vld_s[0] = in_vld;
		x_s[0] = CordicGain;
		y_s[0] = '0;
		a_s[0] = in_ang;
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (!a_s[i][33]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				a_s[i+1] <= a_s[i] - atan_entry(5'(i));
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				a_s[i+1] <= a_s[i] + atan_entry(5'(i));
			end
		end
	end

	assign out_vld = vld_s[CordicSteps];
	assign out_x = x_s[CordicSteps];
	assign out_y = y_s[CordicSteps];
endmodule
`default_nettype wire

/* hw/rtl/bvrr_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Computes num / den; no package items used besides the wildcard import.
`default_nettype none
module bvrr_divider
	import bvrr_pkg::*;
#(
	parameter int NumW = 64,
	parameter int DenW = 33
) (
	input  wire logic            clk,
	input  wire logic [NumW-1:0] num,
	input  wire logic [DenW-1:0] den,
	output logic      [NumW-1:0] quo
);
	logic [NumW-1:0] q_s [NumW+1];
	logic [DenW:0]   r_s [NumW+1];
	logic [DenW-1:0] d_s [NumW+1];

	always_comb begin
		q_s[0] = num;
		r_s[0] = '0;
		d_s[0] = den;
	end

	for (genvar i = 0; i < NumW; i++) begin : g_bit
		logic [DenW:0] sh;
		logic [DenW:0] df;
		assign sh = {r_s[i][DenW-1:0], q_s[i][NumW-1]};
		assign df = sh - {1'b0, d_s[i]};
		always_ff @(posedge clk) begin
			d_s[i+1] <= d_s[i];
			if (!df[DenW]) begin
				r_s[i+1] <= df;
				q_s[i+1] <= {q_s[i][NumW-2:0], 1'b1};
			end else begin
				r_s[i+1] <= sh;
				q_s[i+1] <= {q_s[i][NumW-2:0], 1'b0};
			end
		end
	end

	assign quo = q_s[NumW];
endmodule
`default_nettype wire

/* hw/rtl/bvrr_delay.sv */
// Fixed-length delay line for sideband data that rides beside the long units.
// Uses the wildcard import of bvrr_pkg for house uniformity only.
`default_nettype none
module bvrr_delay
	import bvrr_pkg::*;
#(
	parameter int W = 8,
	parameter int Depth = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_vld,
	input  wire logic [W-1:0] in_dat,
	output logic              out_vld,
	output logic [W-1:0]      out_dat
);
	logic         vld_s [Depth+1];
	logic [W-1:0] dat_s [Depth+1];

	always_comb begin
		vld_s[0] = in_vld;
		dat_s[0] = in_dat;
	end

	for (genvar i = 0; i < Depth; i++) begin : g_tap
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end
		always_ff @(posedge clk) begin
			dat_s[i+1] <= dat_s[i];
		end
	end

	assign out_vld = vld_s[Depth];
	assign out_dat = dat_s[Depth];
endmodule
`default_nettype wire

/* hw/rtl/bone_vector_roll_to_rotation_unit.sv */
// Top level of the bone vector roll to rotation unit.
// Uses bvrr_pkg, bvrr_cordic, bvrr_divider and bvrr_delay.
//
//  channel   signals                               direction
//  request   start, busy, dir_x/y/z, roll_angle     in, busy out
//  result    done, m00 .. m22                       out
//  config    cfg_valid, cfg_ready, cfg_idx, cfg_data in, cfg_ready out
//
// One request is taken every cycle; busy is always low. The pipeline has 72
// register stages: 3 front stages, the 64-stage pipelined divider, the base
// stage and 4 rotation product stages. done and m00 .. m22 are registered
// together in the last stage, R4, so the result is valid while done is high.
// Reset clears all valid bits and loads the register defaults. The receiver
// cannot stall, so the pipeline never holds.
`default_nettype none
module bone_vector_roll_to_rotation_unit
	import bvrr_pkg::*;
#(
	parameter int FRAC_BITS = FracBits
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic signed [31:0]     dir_x,
	input  wire logic signed [31:0]     dir_y,
	input  wire logic signed [31:0]     dir_z,
	input  wire logic signed [15:0]     roll_angle,
	output logic                        done,
	output logic signed [31:0]          m00,
	output logic signed [31:0]          m01,
	output logic signed [31:0]          m02,
	output logic signed [31:0]          m10,
	output logic signed [31:0]          m11,
	output logic signed [31:0]          m12,
	output logic signed [31:0]          m20,
	output logic signed [31:0]          m21,
	output logic signed [31:0]          m22,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [IdxW-1:0]        cfg_idx,
	input  wire logic [31:0]            cfg_data
);
	localparam logic signed [33:0] One = 34'sd1 <<< FRAC_BITS;
	localparam int DivLat = 64;
	// Divider results land at stage 3 + DivLat; CORDIC runs in parallel.
	localparam int DivIn = 3;
	localparam int BaseAt = DivIn + DivLat + 1;

	typedef logic signed [33:0] q_t;
	typedef logic signed [67:0] w_t;

	logic [30:0] near_q, degen_q;
	logic [14:0] dead_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= 31'd10737;
			degen_q <= 31'd1;
			dead_q <= '0;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_NEAR_NEG_Y: near_q <= cfg_data[30:0];
				REG_DEGENERATE: degen_q <= cfg_data[30:0];
				REG_DEADBAND:   dead_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	function automatic q_t sat_q(input w_t v);
		if (v > w_t'(One)) return One;
		if (v < -w_t'(One)) return -One;
		return q_t'(v);
	endfunction

	function automatic q_t mulq(input q_t a, input q_t b);
		w_t p;
		begin
			p = a * b;
			return q_t'(p >>> FRAC_BITS);
		end
	endfunction

	// Stage 1: clamp, theta, roll fold.
	logic vld_s1;
	q_t x_s1, y_s1, z_s1, th_s1, ang_s1;
	logic flip_s1, roll_on_s1;
	q_t cx, cy, cz, af;
	logic [16:0] rmag;
	always_comb begin
		cx = sat_q(w_t'(dir_x));
		cy = sat_q(w_t'(dir_y));
		cz = sat_q(w_t'(dir_z));
		af = q_t'(roll_angle) <<< 16;
		rmag = roll_angle[15] ? 17'(-$signed({roll_angle[15], roll_angle}))
			: 17'({1'b0, roll_angle});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start;
	end
	always_ff @(posedge clk) begin
		x_s1 <= cx; y_s1 <= cy; z_s1 <= cz;
		th_s1 <= One + cy;
		roll_on_s1 <= rmag > 17'(dead_q);
		if (af > (q_t'(1) <<< 30)) begin
			ang_s1 <= af - (q_t'(1) <<< 31); flip_s1 <= 1'b1;
		end else if (af < -(q_t'(1) <<< 30)) begin
			ang_s1 <= af + (q_t'(1) <<< 31); flip_s1 <= 1'b1;
		end else begin
			ang_s1 <= af; flip_s1 <= 1'b0;
		end
	end

	// Stage 2: case select and squares.
	logic vld_s2, flip_s2, roll_on_s2;
	base_case_t bc_s2;
	q_t x_s2, y_s2, z_s2, th_s2;
	w_t xx_s2, zz_s2, xz_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end
	always_ff @(posedge clk) begin
		x_s2 <= x_s1; y_s2 <= y_s1; z_s2 <= z_s1; th_s2 <= th_s1;
		flip_s2 <= flip_s1; roll_on_s2 <= roll_on_s1;
		xx_s2 <= x_s1 * x_s1; zz_s2 <= z_s1 * z_s1; xz_s2 <= x_s1 * z_s1;
		if (th_s1 > q_t'(near_q)) bc_s2 <= CASE_GENERAL;
		else if ((x_s1 != 0 || z_s1 != 0) && th_s1 > q_t'(degen_q)) bc_s2 <= CASE_NEAR;
		else bc_s2 <= CASE_EXACT;
	end

	// Stage 3: form dividends and divisors, with magnitudes and signs.
	// Lanes: 0 -> b00, 1 -> b02, 2 -> b22 (general only).
	logic [63:0] dn_a [3];
	logic [32:0] dd_a [3];
	logic        ng_a [3];
	logic [63:0] dn_s3 [3];
	logic [32:0] dd_s3 [3];
	logic vld_s3;
	w_t nm [3];
	w_t s2;
	logic [67:0] mg, sd;
	logic [6:0] nsh;
	always_comb begin
		s2 = xx_s2 + zz_s2;
		sd = '0;
		// Shift count that brings the sum of squares below 2^32.
		nsh = '0;
		for (int t = 32; t < 68; t++) if (s2[t]) nsh = 7'(t - 31);
		if (bc_s2 == CASE_GENERAL) begin
			nm[0] = xx_s2; nm[1] = xz_s2; nm[2] = zz_s2;
		end else begin
			nm[0] = zz_s2 - xx_s2; nm[1] = xz_s2 <<< 1; nm[2] = '0;
		end
		for (int l = 0; l < 3; l++) begin
			ng_a[l] = nm[l][67];
			mg = ng_a[l] ? 68'(-nm[l]) : 68'(nm[l]);
			if (bc_s2 == CASE_GENERAL) begin
				dn_a[l] = mg[63:0];
				dd_a[l] = th_s2[32:0];
			end else begin
				sd = 68'(s2) >> nsh;
				mg = mg >> nsh;
				if (mg > sd) mg = sd;
				dn_a[l] = 64'(mg << FRAC_BITS);
				dd_a[l] = sd[32:0] | 33'(sd == 0);
			end
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			dn_s3[l] <= dn_a[l]; dd_s3[l] <= dd_a[l];
		end
	end

	logic [63:0] quo [3];
	for (genvar l = 0; l < 3; l++) begin : g_div
		bvrr_divider #(.NumW(64), .DenW(33)) u_div (
			.clk(clk), .num(dn_s3[l]), .den(dd_s3[l]), .quo(quo[l])
		);
	end

	// Sideband: case, signs, vector, roll flags, delayed to divider output.
	localparam int SbW = 2 + 3 + 3*34 + 2;
	logic [SbW-1:0] sb_in, sb_out;
	logic sb_vld;
	assign sb_in = {bc_s2, ng_a[0], ng_a[1], ng_a[2], x_s2, y_s2, z_s2,
		flip_s2, roll_on_s2};
	bvrr_delay #(.W(SbW), .Depth(DivLat + 1)) u_sb (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s2), .in_dat(sb_in),
		.out_vld(sb_vld), .out_dat(sb_out)
	);

	// CORDIC entered from stage 1 angle; delay its output to line up.
	logic cvld, cvld_d;
	q_t cxo, cyo;
	logic [67:0] cs_d;
	bvrr_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s1), .in_ang(ang_s1),
		.out_vld(cvld), .out_x(cxo), .out_y(cyo)
	);
	bvrr_delay #(.W(68), .Depth(BaseAt - 2 - CordicSteps)) u_cs (
		.clk(clk), .arst_n(arst_n), .in_vld(cvld), .in_dat({cxo, cyo}),
		.out_vld(cvld_d), .out_dat(cs_d)
	);

	// Base stage: assemble saturated base matrix, cos, sin.
	base_case_t bc_b;
	q_t x_b, y_b, z_b;
	logic ngd [3];
	logic flip_b, ron_b;
	assign {bc_b, ngd[0], ngd[1], ngd[2], x_b, y_b, z_b, flip_b, ron_b} = sb_out;

	logic vld_b;
	q_t bm_b [3][3];
	q_t c_b, s_b, x_bb, y_bb, z_bb;
	logic ron_bb;
	// Quotients can exceed the Q4.30 range of q_t when theta is tiny; keep them wide.
	w_t qv [3];
	w_t bt [3][3];
	q_t cr, sr;
	always_comb begin
		for (int l = 0; l < 3; l++)
			qv[l] = ngd[l] ? -w_t'(quo[l]) : w_t'(quo[l]);
		for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) bt[i][j] = '0;
		unique case (bc_b)
			CASE_GENERAL: begin
				bt[0][0] = w_t'(One) - qv[0]; bt[2][2] = w_t'(One) - qv[2];
				bt[0][2] = -qv[1]; bt[2][0] = -qv[1];
			end
			CASE_NEAR: begin
				bt[0][0] = qv[0]; bt[2][2] = -qv[0];
				bt[0][2] = qv[1]; bt[2][0] = qv[1];
			end
			default: begin
				bt[0][0] = -w_t'(One); bt[1][1] = -w_t'(One); bt[2][2] = w_t'(One);
			end
		endcase
		if (bc_b != CASE_EXACT) begin
			bt[1][0] = -w_t'(x_b); bt[0][1] = w_t'(x_b); bt[1][1] = w_t'(y_b);
			bt[2][1] = w_t'(z_b); bt[1][2] = -w_t'(z_b);
		end
		cr = $signed(cs_d[67:34]) >>> (30 - FRAC_BITS);
		sr = $signed(cs_d[33:0]) >>> (30 - FRAC_BITS);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_b <= 1'b0;
		else vld_b <= sb_vld;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++)
			bm_b[i][j] <= sat_q(bt[i][j]);
		c_b <= flip_b ? -cr : cr;
		s_b <= flip_b ? -sr : sr;
		x_bb <= x_b; y_bb <= y_b; z_bb <= z_b; ron_bb <= ron_b;
	end

	// R1: outer products n*n^T and s*n.
	logic vld_r1, ron_r1;
	q_t nn_r1 [3][3];
	q_t sn_r1 [3];
	q_t c_r1, t_r1;
	q_t bm_r1 [3][3];
	q_t nv [3];
	assign nv[0] = x_bb; assign nv[1] = y_bb; assign nv[2] = z_bb;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_r1 <= 1'b0;
		else vld_r1 <= vld_b;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) nn_r1[i][j] <= mulq(nv[i], nv[j]);
			sn_r1[i] <= mulq(s_b, nv[i]);
		end
		c_r1 <= c_b; t_r1 <= One - c_b; bm_r1 <= bm_b; ron_r1 <= ron_bb;
	end

	// R2: rotation matrix R.
	logic vld_r2, ron_r2;
	q_t r_r2 [3][3];
	q_t bm_r2 [3][3];
	q_t ra [3][3];
	always_comb begin
		for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++)
			ra[i][j] = (i == j ? c_r1 : q_t'(0)) + mulq(t_r1, nn_r1[i][j]);
		ra[0][1] = ra[0][1] - sn_r1[2]; ra[0][2] = ra[0][2] + sn_r1[1];
		ra[1][0] = ra[1][0] + sn_r1[2]; ra[1][2] = ra[1][2] - sn_r1[0];
		ra[2][0] = ra[2][0] - sn_r1[1]; ra[2][1] = ra[2][1] + sn_r1[0];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_r2 <= 1'b0;
		else vld_r2 <= vld_r1;
	end
	always_ff @(posedge clk) begin
		r_r2 <= ra; bm_r2 <= bm_r1; ron_r2 <= ron_r1;
	end

	// R3: the 27 products of R*B.
	logic vld_r3, ron_r3;
	q_t pp_r3 [3][3][3];
	q_t bm_r3 [3][3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_r3 <= 1'b0;
		else vld_r3 <= vld_r2;
	end
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++)
			for (int l = 0; l < 3; l++) pp_r3[i][j][l] <= mulq(r_r2[i][l], bm_r2[l][j]);
		bm_r3 <= bm_r2; ron_r3 <= ron_r2;
	end

	// R4: sum, saturate, select and register the result.
	q_t mo [3][3];
	always_comb begin
		for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++)
			mo[i][j] = ron_r3 ? sat_q(w_t'(pp_r3[i][j][0]) + w_t'(pp_r3[i][j][1])
				+ w_t'(pp_r3[i][j][2])) : bm_r3[i][j];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_r3;
	end
	always_ff @(posedge clk) begin
		m00 <= mo[0][0][31:0]; m01 <= mo[0][1][31:0]; m02 <= mo[0][2][31:0];
		m10 <= mo[1][0][31:0]; m11 <= mo[1][1][31:0]; m12 <= mo[1][2][31:0];
		m20 <= mo[2][0][31:0]; m21 <= mo[2][1][31:0]; m22 <= mo[2][2][31:0];
	end

	logic unused_ok;
	assign unused_ok = &{1'b0, cvld_d};
endmodule
`default_nettype wire
